/* rtl/core/gas_pkg.sv */
// ----------------------------------------------------------------------------
// gas_pkg: glyph atlas shelf allocator shared definitions
// Field widths and status codes used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int GLYPH_W    = 10;
  localparam int CELL_W     = 11;
  localparam int STATUS_W   = 2;
  localparam int PAGE_IDX_W = 6;
  localparam int POS_W      = 9;
  localparam int CELL_OUT_W = 9;

  localparam logic [STATUS_W-1:0] ST_PLACED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd2;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_width;
    logic [GLYPH_W-1:0] glyph_height;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [POS_W-1:0]      draw_x;
    logic [POS_W-1:0]      draw_y;
    logic [CELL_OUT_W-1:0] cell_width;
    logic [CELL_OUT_W-1:0] cell_height;
    logic                  new_page;
  } res_t;

endpackage

/* rtl/core/gas_req_if.sv */
// ----------------------------------------------------------------------------
// gas_req_if: glyph request channel
// Valid/ready channel carrying one glyph size request per item.
// ----------------------------------------------------------------------------
interface gas_req_if;

  logic                        valid;
  logic                        ready;
  logic [gas_pkg::GLYPH_W-1:0] glyph_width;
  logic [gas_pkg::GLYPH_W-1:0] glyph_height;

  modport source (output valid, output glyph_width, output glyph_height, input ready);
  modport sink   (input valid, input glyph_width, input glyph_height, output ready);

endinterface

/* rtl/core/gas_res_if.sv */
// ----------------------------------------------------------------------------
// gas_res_if: allocation result channel
// Valid/ready channel carrying one placement result per item.
// ----------------------------------------------------------------------------
interface gas_res_if;

  logic                           valid;
  logic                           ready;
  logic [gas_pkg::STATUS_W-1:0]   status;
  logic [gas_pkg::PAGE_IDX_W-1:0] page_index;
  logic [gas_pkg::POS_W-1:0]      draw_x;
  logic [gas_pkg::POS_W-1:0]      draw_y;
  logic [gas_pkg::CELL_OUT_W-1:0] cell_width;
  logic [gas_pkg::CELL_OUT_W-1:0] cell_height;
  logic                           new_page;

  modport source (output valid, output status, output page_index, output draw_x,
                  output draw_y, output cell_width, output cell_height,
                  output new_page, input ready);
  modport sink   (input valid, input status, input page_index, input draw_x,
                  input draw_y, input cell_width, input cell_height,
                  input new_page, output ready);

endinterface

/* rtl/core/glyph_atlas_shelf_allocator.sv */
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator: shelf packer for a glyph texture atlas
// Rounds glyph sizes to power-of-two cells and places them in rows on
// square pages, opening a new page when needed.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink)   : one glyph width/height per item, taken on valid && ready.
//   res (source) : one result item per request, in request order: status,
//                  page, cell origin, rounded cell size and new-page flag.
//   A taken request waits in the input register until its result moves to
//   the output register. Throughput: one item per cycle while res.ready is
//   high, set by one update of the page/row/cursor registers per item.
//   An input register holds one item while a result waits in the output
//   register, so one further request is taken during a stall; after that
//   req.ready stays low until res.ready returns.
//   Rejected requests (too large, out of pages) leave the page state alone.
//   Reset (rst, synchronous) empties both registers and returns to no page
//   open, row height zero and cursor at the origin. Texture creation and
//   clearing are up to software, which watches new_page.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_allocator #(
  parameter int PAGE_SIZE = 512,
  parameter int MIN_CELL  = 16,
  parameter int MAX_CELL  = 256,
  parameter int MAX_PAGES = 64
) (
  input  logic      clk,
  input  logic      rst,
  gas_req_if.sink   req,
  gas_res_if.source res
);

  localparam int AW = $clog2(PAGE_SIZE + 2 * MAX_CELL + 1);
  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int CW = gas_pkg::CELL_W;
  localparam int GW = gas_pkg::GLYPH_W;

  localparam logic [CW-1:0] MIN_V    = CW'(MIN_CELL);
  localparam logic [CW-1:0] MAX_V    = CW'(MAX_CELL);
  localparam logic [AW-1:0] PAGE_V   = AW'(PAGE_SIZE);
  localparam logic [PW-1:0] PAGES_V  = PW'(MAX_PAGES);

  function automatic logic [CW-1:0] round_cell(input logic [GW-1:0] v);
    logic [GW-1:0] s;
    s = v - GW'(1);
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    if (CW'(v) <= MIN_V) begin
      return MIN_V;
    end
    return CW'(s) + CW'(1);
  endfunction

  // input register
  logic         in_full;
  gas_pkg::req_t in_q;

  // output register
  logic          out_valid;
  gas_pkg::res_t out_q;
  gas_pkg::res_t out_next;

  // page state
  logic [PW-1:0] pages_used;
  logic [CW-1:0] row_height;
  logic [AW-1:0] cursor_x;
  logic [AW-1:0] cursor_y;
  logic [PW-1:0] pages_used_next;
  logic [CW-1:0] row_height_next;
  logic [AW-1:0] cursor_x_next;
  logic [AW-1:0] cursor_y_next;

  logic          advance;
  logic [CW-1:0] cw;
  logic [CW-1:0] ch;
  logic          too_large;
  logic          fresh;
  logic          no_page;
  logic          placed;
  logic          wrap;
  logic [AW-1:0] x0;
  logic [AW-1:0] y0;
  logic [CW-1:0] rh;
  logic [AW-1:0] dx;
  logic [AW-1:0] dy;

  assign advance   = in_full && (!out_valid || res.ready);
  assign req.ready = !in_full || advance;

  always_comb begin
    cw        = round_cell(in_q.glyph_width);
    ch        = round_cell(in_q.glyph_height);
    too_large = (ch > MAX_V) || (cw > MAX_V);
    fresh     = (pages_used == '0) || (row_height != ch) ||
                ((cursor_y + AW'(ch) >= PAGE_V) && (cursor_x + AW'(cw) >= PAGE_V));
    no_page   = !too_large && fresh && (pages_used >= PAGES_V);
    placed    = !too_large && !no_page;

    x0   = fresh ? '0 : cursor_x;
    y0   = fresh ? '0 : cursor_y;
    rh   = fresh ? ch : row_height;
    wrap = (x0 + AW'(cw)) >= PAGE_V;
    dx   = wrap ? '0 : x0;
    dy   = wrap ? (y0 + AW'(rh)) : y0;

    pages_used_next = pages_used;
    row_height_next = row_height;
    cursor_x_next   = cursor_x;
    cursor_y_next   = cursor_y;
    out_next        = '0;

    priority if (too_large) begin
      out_next.status = gas_pkg::ST_TOO_LARGE;
    end else if (no_page) begin
      out_next.status = gas_pkg::ST_NO_PAGE;
    end else begin
      pages_used_next      = pages_used + PW'(fresh);
      row_height_next      = rh;
      cursor_x_next        = dx + AW'(cw);
      cursor_y_next        = dy;
      out_next.status      = gas_pkg::ST_PLACED;
      out_next.page_index  = gas_pkg::PAGE_IDX_W'(pages_used_next - PW'(1));
      out_next.draw_x      = gas_pkg::POS_W'(dx);
      out_next.draw_y      = gas_pkg::POS_W'(dy);
      out_next.cell_width  = gas_pkg::CELL_OUT_W'(cw);
      out_next.cell_height = gas_pkg::CELL_OUT_W'(ch);
      out_next.new_page    = fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      out_valid  <= 1'b0;
      pages_used <= '0;
      row_height <= '0;
      cursor_x   <= '0;
      cursor_y   <= '0;
    end else begin
      if (req.valid && req.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        pages_used <= pages_used_next;
        row_height <= row_height_next;
        cursor_x   <= cursor_x_next;
        cursor_y   <= cursor_y_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.glyph_width  <= req.glyph_width;
      in_q.glyph_height <= req.glyph_height;
    end
    if (advance) begin
      out_q <= out_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_q.status;
  assign res.page_index  = out_q.page_index;
  assign res.draw_x      = out_q.draw_x;
  assign res.draw_y      = out_q.draw_y;
  assign res.cell_width  = out_q.cell_width;
  assign res.cell_height = out_q.cell_height;
  assign res.new_page    = out_q.new_page;

  // page state moves only when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pages_used) && $stable(cursor_x) && $stable(cursor_y)
                 && $stable(row_height))
    else $error("page state changed without an item");

  // a new page takes the cell height of the item that opened it
  a_fresh_row: assert property (@(posedge clk) disable iff (rst)
    advance && placed && fresh |=> (row_height == $past(ch)) && (cursor_y == $past(dy)))
    else $error("new page row height mismatch");

  a_page_limit: assert property (@(posedge clk) disable iff (rst)
    pages_used <= PAGES_V)
    else $error("page count beyond limit");

  // a held request is not lost while the result stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_q))
    else $error("held request dropped");

endmodule

/* sim/glyph_atlas_shelf_allocator_tb.sv */
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator_tb: self-checking bench for the shelf allocator
// Drives glyph size requests through the request channel and checks every
// placement against a cycle-free shelf tracker kept in a scoreboard class.
// Directed corner cases come first, then a long result stall, then runs of
// equal row height with random widths mixed with noise, and a closing
// page-exhaustion sweep with both channels at full rate.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_allocator_tb;

  localparam int PAGE_SIZE   = 512;
  localparam int MIN_CELL    = 16;
  localparam int MAX_CELL    = 256;
  localparam int MAX_PAGES   = 64;
  localparam int STALL_LIMIT = 2000;

  class shelf_scoreboard;
    gas_pkg::res_t expected_results[$];
    int   pages_open;
    int   shelf_height;
    int   cursor_x;
    int   cursor_y;
    int   errors;
    int   n_placed;
    int   n_too_large;
    int   n_no_page;
    int   n_new_page;
    int   n_wraps;

    function int cell_size(input int v);
      int p;
      p = 1;
      if (v <= MIN_CELL) return MIN_CELL;
      while (p < v) p = p << 1;
      return p;
    endfunction

    function void note_request(input logic [gas_pkg::GLYPH_W-1:0] w,
                               input logic [gas_pkg::GLYPH_W-1:0] h);
      int            cw;
      int            ch;
      bit            fresh;
      gas_pkg::res_t r;
      cw = cell_size(int'(w));
      ch = cell_size(int'(h));
      r  = '0;
      if (cw > MAX_CELL || ch > MAX_CELL) begin
        r.status = gas_pkg::ST_TOO_LARGE;
        n_too_large++;
      end else begin
        fresh = (pages_open == 0) || (shelf_height != ch) ||
                ((cursor_y + ch >= PAGE_SIZE) && (cursor_x + cw >= PAGE_SIZE));
        if (fresh && pages_open >= MAX_PAGES) begin
          r.status = gas_pkg::ST_NO_PAGE;
          n_no_page++;
        end else begin
          if (fresh) begin
            pages_open++;
            shelf_height = ch;
            cursor_x = 0;
            cursor_y = 0;
            n_new_page++;
          end
          if (cursor_x + cw >= PAGE_SIZE) begin
            cursor_x = 0;
            cursor_y += shelf_height;
            n_wraps++;
          end
          r.status      = gas_pkg::ST_PLACED;
          r.page_index  = gas_pkg::PAGE_IDX_W'(pages_open - 1);
          r.draw_x      = gas_pkg::POS_W'(cursor_x);
          r.draw_y      = gas_pkg::POS_W'(cursor_y);
          r.cell_width  = gas_pkg::CELL_OUT_W'(cw);
          r.cell_height = gas_pkg::CELL_OUT_W'(ch);
          r.new_page    = fresh;
          cursor_x += cw;
          n_placed++;
        end
      end
      expected_results = {expected_results, r};
    endfunction

    function void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_placement(input gas_pkg::res_t act);
      gas_pkg::res_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, act);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      check_field("status", int'(e.status), int'(act.status));
      check_field("page_index", int'(e.page_index), int'(act.page_index));
      check_field("draw_x", int'(e.draw_x), int'(act.draw_x));
      check_field("draw_y", int'(e.draw_y), int'(act.draw_y));
      check_field("cell_width", int'(e.cell_width), int'(act.cell_width));
      check_field("cell_height", int'(e.cell_height), int'(act.cell_height));
      check_field("new_page", int'(e.new_page), int'(act.new_page));
    endfunction
  endclass

  logic clk;
  logic rst;

  gas_req_if req_ch ();
  gas_res_if res_ch ();

  glyph_atlas_shelf_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  shelf_scoreboard sb = new();

  bit idling;
  int sink_hold_cycles;
  int quiet_cycles;
  int sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random back-pressure plus an on-request long stall
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gas_pkg::res_t act;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        act.status      = res_ch.status;
        act.page_index  = res_ch.page_index;
        act.draw_x      = res_ch.draw_x;
        act.draw_y      = res_ch.draw_y;
        act.cell_width  = res_ch.cell_width;
        act.cell_height = res_ch.cell_height;
        act.new_page    = res_ch.new_page;
        sb.check_placement(act);
      end
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.glyph_width, req_ch.glyph_height);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("glyph_atlas_shelf_allocator_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge the item is taken
  task automatic send_request(input int w, input int h);
    if (idling && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.glyph_width  <= gas_pkg::GLYPH_W'(w);
    req_ch.glyph_height <= gas_pkg::GLYPH_W'(h);
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // random size that rounds to the given cell class
  function automatic int size_in_class(input int cls);
    if (cls <= MIN_CELL) return $urandom_range(0, MIN_CELL);
    return $urandom_range(cls / 2 + 1, cls);
  endfunction

  function automatic int pick_row_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16;
    if (r < 45) return 32;
    if (r < 70) return 64;
    if (r < 90) return 128;
    return 256;
  endfunction

  initial begin
    int run_h;
    int run_len;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.glyph_width  <= '0;
    req_ch.glyph_height <= '0;
    idling           = 1'b0;
    sink_hold_cycles = 0;
    sent             = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners: minimum cells, rejects, wraps, full last row
    send_request(0, 0);
    send_request(16, 16);
    send_request(17, 1);
    send_request(1023, 1023);
    send_request(257, 10);
    send_request(10, 257);
    send_request(512, 0);
    send_request(256, 256);
    send_request(256, 256);
    send_request(200, 255);
    send_request(129, 256);
    send_request(255, 129);
    send_request(1, 1);
    send_request(33, 32);
    send_request(64, 64);
    send_request(65, 100);
    send_request(128, 128);
    send_request(256, 128);
    send_request(256, 128);
    send_request(256, 128);
    send_request(256, 128);
    send_request(0, 511);
    send_request(511, 0);
    drain_results();

    // long result stall with requests still offered
    sink_hold_cycles = 40;
    for (int i = 0; i < 12; i++) send_request($urandom_range(0, 256), 64);
    drain_results();

    idling = 1'b1;
    while (sent < 440) begin
      if ($urandom_range(0, 99) < 85) begin
        run_h   = pick_row_class();
        run_len = $urandom_range(3, 25);
        for (int i = 0; i < run_len; i++)
          send_request(size_in_class(16 << $urandom_range(0, 4)), size_in_class(run_h));
      end else begin
        send_request($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();

    // full rate: alternate row heights until pages run out, then mixed sizes
    idling = 1'b0;
    for (int i = 0; i < 80; i++) send_request($urandom_range(0, 256), (i % 2) ? 20 : 200);
    for (int i = 0; i < 30; i++)
      send_request(size_in_class(16 << $urandom_range(0, 4)), size_in_class(pick_row_class()));
    drain_results();
    repeat (5) @(posedge clk);

    $display("run covered %0d requests: %0d placed on %0d pages with %0d row wraps",
             sent, sb.n_placed, sb.n_new_page, sb.n_wraps);
    $display("rejected %0d as too large and %0d for want of a page",
             sb.n_too_large, sb.n_no_page);
    if (sb.expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("glyph_atlas_shelf_allocator_tb: clean");
    end else begin
      $display("glyph_atlas_shelf_allocator_tb: errors");
    end
    $finish;
  end

endmodule
